// File: design/usbep0_pkg.sv
// ----------------------------------------------------------------------------
// usbep0_pkg - shared types and codes for the EP0 control transfer handler
// Holds the event, response and phase encodings, the setup request codes,
// packet source codes and the structs passed between the block's modules.
// ----------------------------------------------------------------------------
package usbep0_pkg;

    // largest EP0 packet, default for the top level parameter
    localparam int MAX_PACKET_DEF = 64;

    // configuration register indexes
    localparam int          CFG_INDEX_W       = 3;
    localparam int          CFG_DATA_W        = 16;
    localparam logic [2:0]  CFG_DEVICE_LEN    = 3'd0;
    localparam logic [2:0]  CFG_CONFIG_LEN    = 3'd1;
    localparam logic [2:0]  CFG_QUALIFIER_LEN = 3'd2;
    localparam logic [2:0]  CFG_STRING0_LEN   = 3'd3;
    localparam logic [2:0]  CFG_STRING1_LEN   = 3'd4;
    localparam logic [2:0]  CFG_STRING2_LEN   = 3'd5;

    // register reset values
    localparam logic [7:0]  RST_DEVICE_LEN    = 8'd18;
    localparam logic [15:0] RST_CONFIG_LEN    = 16'd127;
    localparam logic [7:0]  RST_QUALIFIER_LEN = 8'd10;
    localparam logic [7:0]  RST_STRING0_LEN   = 8'd4;
    localparam logic [7:0]  RST_STRING1_LEN   = 8'd0;
    localparam logic [7:0]  RST_STRING2_LEN   = 8'd0;

    // bmRequestType type field (bits 6:5)
    localparam logic [1:0]  RT_STANDARD = 2'd0;
    localparam logic [1:0]  RT_CLASS    = 2'd1;
    localparam logic [1:0]  RT_VENDOR   = 2'd2;
    localparam logic [1:0]  RT_RESERVED = 2'd3;

    // standard request codes
    localparam logic [7:0]  REQ_GET_STATUS     = 8'h00;
    localparam logic [7:0]  REQ_SET_ADDRESS    = 8'h05;
    localparam logic [7:0]  REQ_GET_DESCRIPTOR = 8'h06;
    localparam logic [7:0]  REQ_GET_CONFIG     = 8'h08;
    localparam logic [7:0]  REQ_SET_CONFIG     = 8'h09;
    localparam logic [7:0]  REQ_SET_INTERFACE  = 8'h0b;
    // vendor keep-alive request
    localparam logic [7:0]  REQ_KEEPALIVE      = 8'h01;

    // descriptor types
    localparam logic [7:0]  DESC_DEVICE    = 8'h01;
    localparam logic [7:0]  DESC_CONFIG    = 8'h02;
    localparam logic [7:0]  DESC_STRING    = 8'h03;
    localparam logic [7:0]  DESC_QUALIFIER = 8'h06;

    // string descriptor indexes
    localparam logic [7:0]  STR_LANGUAGE     = 8'd0;
    localparam logic [7:0]  STR_MANUFACTURER = 8'd1;
    localparam logic [7:0]  STR_PRODUCT      = 8'd2;

    // packet sources
    localparam logic [3:0]  SRC_NONE      = 4'd0;
    localparam logic [3:0]  SRC_DEVICE    = 4'd1;
    localparam logic [3:0]  SRC_CONFIG    = 4'd2;
    localparam logic [3:0]  SRC_STRING0   = 4'd3;
    localparam logic [3:0]  SRC_STRING1   = 4'd4;
    localparam logic [3:0]  SRC_STRING2   = 4'd5;
    localparam logic [3:0]  SRC_QUALIFIER = 4'd6;
    localparam logic [3:0]  SRC_STATUS    = 4'd7;
    localparam logic [3:0]  SRC_CFG_BYTE  = 4'd8;
    localparam logic [3:0]  SRC_KEEPALIVE = 4'd9;

    // fixed object lengths
    localparam logic [15:0] LEN_NONE      = 16'd0;
    localparam logic [15:0] LEN_STATUS    = 16'd2;
    localparam logic [15:0] LEN_CFG_BYTE  = 16'd1;
    localparam logic [15:0] LEN_KEEPALIVE = 16'd4;

    typedef enum logic [1:0] {
        ACT_SETUP     = 2'd0,
        ACT_IN_DONE   = 2'd1,
        ACT_OUT_DONE  = 2'd2,
        ACT_BUS_RESET = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        RSP_NONE  = 3'd0,
        RSP_STALL = 3'd1,
        RSP_DATA  = 3'd2,
        RSP_ZLP   = 3'd3,
        RSP_ARM   = 3'd4,
        RSP_FWD   = 3'd5
    } t_response;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DATA   = 2'd1,
        PH_STATUS = 2'd2,
        PH_FWD    = 2'd3
    } t_phase;

    typedef struct packed {
        t_action     action;
        logic [7:0]  request_type;
        logic [7:0]  request_code;
        logic [15:0] request_value;
        logic [15:0] request_index;
        logic [15:0] request_length;
    } t_item;

    typedef struct packed {
        logic [7:0]  device_len;
        logic [15:0] config_len;
        logic [7:0]  qualifier_len;
        logic [7:0]  string0_len;
        logic [7:0]  string1_len;
        logic [7:0]  string2_len;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] total_bytes;
        logic [15:0] sent_bytes;
        logic        zlp_pending;
        logic [3:0]  source_id;
        logic        config_value;
        logic        stream_enabled;
    } t_state;

    typedef struct packed {
        t_response   response;
        logic [3:0]  packet_source;
        logic [15:0] packet_offset;
        logic [6:0]  packet_length;
        logic        address_update;
        logic [6:0]  new_address;
        logic        configured;
        logic        streaming_on;
        logic        transfer_done;
    } t_result;

    // bytes of the next packet: what is left, capped at the packet size
    function automatic logic [15:0] clamp_packet(input logic [15:0] left,
                                                 input logic [15:0] max_pkt);
        return (left > max_pkt) ? max_pkt : left;
    endfunction

endpackage

// File: design/usbep0_cfg.sv
// ----------------------------------------------------------------------------
// usbep0_cfg - descriptor length registers
// Six write-only registers holding the descriptor lengths used to size the
// data stages; reset to the default descriptor set.
// ----------------------------------------------------------------------------
module usbep0_cfg (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [usbep0_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [usbep0_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output usbep0_pkg::t_cfg                   o_cfg
);

    usbep0_pkg::t_cfg r_cfg;
    usbep0_pkg::t_cfg n_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                usbep0_pkg::CFG_DEVICE_LEN:    n_cfg.device_len    = i_cfg_data[7:0];
                usbep0_pkg::CFG_CONFIG_LEN:    n_cfg.config_len    = i_cfg_data[15:0];
                usbep0_pkg::CFG_QUALIFIER_LEN: n_cfg.qualifier_len = i_cfg_data[7:0];
                usbep0_pkg::CFG_STRING0_LEN:   n_cfg.string0_len   = i_cfg_data[7:0];
                usbep0_pkg::CFG_STRING1_LEN:   n_cfg.string1_len   = i_cfg_data[7:0];
                usbep0_pkg::CFG_STRING2_LEN:   n_cfg.string2_len   = i_cfg_data[7:0];
                default:                       n_cfg               = r_cfg;
            endcase
        end
    end

    // register bank
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.device_len    <= usbep0_pkg::RST_DEVICE_LEN;
            r_cfg.config_len    <= usbep0_pkg::RST_CONFIG_LEN;
            r_cfg.qualifier_len <= usbep0_pkg::RST_QUALIFIER_LEN;
            r_cfg.string0_len   <= usbep0_pkg::RST_STRING0_LEN;
            r_cfg.string1_len   <= usbep0_pkg::RST_STRING1_LEN;
            r_cfg.string2_len   <= usbep0_pkg::RST_STRING2_LEN;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

// File: design/usbep0_decode.sv
// ----------------------------------------------------------------------------
// usbep0_decode - request decode and transfer sequencing
// Combinational: takes one registered EP0 event with the current transfer
// state and gives the next state and the result word for that event.
// ----------------------------------------------------------------------------
module usbep0_decode #(
    parameter int MAX_PACKET = usbep0_pkg::MAX_PACKET_DEF
) (
    input  usbep0_pkg::t_item   i_item,
    input  usbep0_pkg::t_state  i_state,
    input  usbep0_pkg::t_cfg    i_cfg,
    output usbep0_pkg::t_state  o_next_state,
    output usbep0_pkg::t_result o_result
);

    localparam logic [15:0] MaxPkt = 16'(MAX_PACKET);

    // decoded setup request
    logic        d_stall;
    logic        d_fwd;
    logic        d_send;
    logic [3:0]  d_src;
    logic [15:0] d_obj_len;
    logic        d_set_cfg;
    logic        d_set_stream;
    logic        d_aupd;
    logic [6:0]  d_addr;

    logic [7:0]  descr_kind;
    logic [7:0]  value_lo;
    logic [15:0] wlen;

    // first packet of a new data stage
    logic [15:0] st_lim;
    logic [15:0] st_sz;
    logic        st_zlp;

    // following packet of a running data stage
    logic [15:0] np_rem;
    logic [15:0] np_sz;
    logic [15:0] np_sent;
    logic        np_zlp;

    usbep0_pkg::t_state n_st;

    assign descr_kind = i_item.request_value[15:8];
    assign value_lo   = i_item.request_value[7:0];
    assign wlen       = i_item.request_length;

    // setup request decode
    always_comb begin
        d_stall      = 1'b0;
        d_fwd        = 1'b0;
        d_send       = 1'b0;
        d_src        = usbep0_pkg::SRC_NONE;
        d_obj_len    = usbep0_pkg::LEN_NONE;
        d_set_cfg    = 1'b0;
        d_set_stream = 1'b0;
        d_aupd       = 1'b0;
        d_addr       = 7'd0;
        unique case (i_item.request_type[6:5])
            usbep0_pkg::RT_STANDARD: begin
                unique case (i_item.request_code)
                    usbep0_pkg::REQ_GET_STATUS: begin
                        d_send    = 1'b1;
                        d_src     = usbep0_pkg::SRC_STATUS;
                        d_obj_len = usbep0_pkg::LEN_STATUS;
                    end
                    usbep0_pkg::REQ_SET_ADDRESS: begin
                        if (i_item.request_index == 16'd0 && wlen == 16'd0) begin
                            d_send = 1'b1;
                            d_aupd = 1'b1;
                            d_addr = i_item.request_value[6:0];
                        end else begin
                            d_stall = 1'b1;
                        end
                    end
                    usbep0_pkg::REQ_GET_DESCRIPTOR: begin
                        d_send = 1'b1;
                        unique case (descr_kind)
                            usbep0_pkg::DESC_DEVICE: begin
                                d_src     = usbep0_pkg::SRC_DEVICE;
                                d_obj_len = {8'd0, i_cfg.device_len};
                            end
                            usbep0_pkg::DESC_CONFIG: begin
                                d_src     = usbep0_pkg::SRC_CONFIG;
                                d_obj_len = i_cfg.config_len;
                            end
                            usbep0_pkg::DESC_QUALIFIER: begin
                                d_src     = usbep0_pkg::SRC_QUALIFIER;
                                d_obj_len = {8'd0, i_cfg.qualifier_len};
                            end
                            usbep0_pkg::DESC_STRING: begin
                                unique case (value_lo)
                                    usbep0_pkg::STR_LANGUAGE: begin
                                        d_src     = usbep0_pkg::SRC_STRING0;
                                        d_obj_len = {8'd0, i_cfg.string0_len};
                                    end
                                    usbep0_pkg::STR_MANUFACTURER: begin
                                        d_src     = usbep0_pkg::SRC_STRING1;
                                        d_obj_len = {8'd0, i_cfg.string1_len};
                                    end
                                    usbep0_pkg::STR_PRODUCT: begin
                                        d_src     = usbep0_pkg::SRC_STRING2;
                                        d_obj_len = {8'd0, i_cfg.string2_len};
                                    end
                                    default: begin
                                        d_src     = usbep0_pkg::SRC_NONE;
                                        d_obj_len = usbep0_pkg::LEN_NONE;
                                    end
                                endcase
                            end
                            default: begin
                                d_src     = usbep0_pkg::SRC_NONE;
                                d_obj_len = usbep0_pkg::LEN_NONE;
                            end
                        endcase
                        // unknown selector or empty descriptor
                        if (d_obj_len == 16'd0) begin
                            d_send  = 1'b0;
                            d_stall = 1'b1;
                        end
                    end
                    usbep0_pkg::REQ_GET_CONFIG: begin
                        d_send    = 1'b1;
                        d_src     = usbep0_pkg::SRC_CFG_BYTE;
                        d_obj_len = usbep0_pkg::LEN_CFG_BYTE;
                    end
                    usbep0_pkg::REQ_SET_CONFIG: begin
                        if (value_lo <= 8'd1) begin
                            d_send    = 1'b1;
                            d_set_cfg = 1'b1;
                        end else begin
                            d_stall = 1'b1;
                        end
                    end
                    usbep0_pkg::REQ_SET_INTERFACE: begin
                        // interface 0 has only alt 0, interface 1 has alt 0 and 1
                        if (i_item.request_index[7:0] == 8'd0 && value_lo == 8'd0) begin
                            d_send = 1'b1;
                        end else if (i_item.request_index[7:0] == 8'd1 &&
                                     value_lo <= 8'd1) begin
                            d_send       = 1'b1;
                            d_set_stream = 1'b1;
                        end else begin
                            d_stall = 1'b1;
                        end
                    end
                    default: d_stall = 1'b1;
                endcase
            end
            usbep0_pkg::RT_CLASS: d_fwd = 1'b1;
            usbep0_pkg::RT_VENDOR: begin
                if (i_item.request_code == usbep0_pkg::REQ_KEEPALIVE) begin
                    d_send    = 1'b1;
                    d_src     = usbep0_pkg::SRC_KEEPALIVE;
                    d_obj_len = usbep0_pkg::LEN_KEEPALIVE;
                end else begin
                    d_stall = 1'b1;
                end
            end
            usbep0_pkg::RT_RESERVED: d_stall = 1'b1;
            default: d_stall = 1'b1;
        endcase
    end

    // packet sizing
    assign st_lim  = (wlen < d_obj_len) ? wlen : d_obj_len;
    assign st_sz   = usbep0_pkg::clamp_packet(st_lim, MaxPkt);
    assign st_zlp  = (st_lim == MaxPkt);
    assign np_rem  = i_state.total_bytes - i_state.sent_bytes;
    assign np_sz   = usbep0_pkg::clamp_packet(np_rem, MaxPkt);
    assign np_sent = i_state.sent_bytes + np_sz;
    assign np_zlp  = (np_sz == MaxPkt) && (np_sent == i_state.total_bytes);

    // next transfer state
    always_comb begin
        n_st = i_state;
        unique case (i_item.action)
            usbep0_pkg::ACT_SETUP: begin
                n_st.total_bytes = wlen;
                n_st.sent_bytes  = 16'd0;
                n_st.zlp_pending = 1'b0;
                if (d_fwd) begin
                    n_st.phase = usbep0_pkg::PH_FWD;
                end else if (d_stall) begin
                    n_st.phase = usbep0_pkg::PH_IDLE;
                end else if (d_send) begin
                    n_st.phase       = usbep0_pkg::PH_DATA;
                    n_st.source_id   = d_src;
                    n_st.total_bytes = st_lim;
                    if (st_lim != 16'd0) begin
                        n_st.sent_bytes  = st_sz;
                        n_st.zlp_pending = st_zlp;
                    end
                    if (d_set_cfg) begin
                        n_st.config_value = value_lo[0];
                    end
                    if (d_set_stream) begin
                        n_st.stream_enabled = value_lo[0];
                    end
                end
            end
            usbep0_pkg::ACT_IN_DONE: begin
                if (i_state.phase == usbep0_pkg::PH_DATA) begin
                    if (np_rem != 16'd0) begin
                        n_st.sent_bytes = np_sent;
                        if (np_zlp) begin
                            n_st.zlp_pending = 1'b1;
                        end
                    end else if (i_state.zlp_pending) begin
                        n_st.zlp_pending = 1'b0;
                    end else begin
                        n_st.phase = usbep0_pkg::PH_STATUS;
                    end
                end
            end
            usbep0_pkg::ACT_OUT_DONE: begin
                if (i_state.phase == usbep0_pkg::PH_STATUS) begin
                    n_st.phase = usbep0_pkg::PH_IDLE;
                end
            end
            usbep0_pkg::ACT_BUS_RESET: n_st.phase = usbep0_pkg::PH_IDLE;
            default: n_st = i_state;
        endcase
    end

    assign o_next_state = n_st;

    // result word
    always_comb begin
        o_result              = '0;
        o_result.response     = usbep0_pkg::RSP_NONE;
        o_result.configured   = n_st.config_value;
        o_result.streaming_on = n_st.stream_enabled;
        unique case (i_item.action)
            usbep0_pkg::ACT_SETUP: begin
                o_result.address_update = d_aupd;
                o_result.new_address    = d_addr;
                if (d_fwd) begin
                    o_result.response = usbep0_pkg::RSP_FWD;
                end else if (d_stall) begin
                    o_result.response = usbep0_pkg::RSP_STALL;
                end else if (d_send) begin
                    o_result.packet_source = d_src;
                    if (st_lim == 16'd0) begin
                        o_result.response = usbep0_pkg::RSP_ZLP;
                    end else begin
                        o_result.response      = usbep0_pkg::RSP_DATA;
                        o_result.packet_length = st_sz[6:0];
                    end
                end
            end
            usbep0_pkg::ACT_IN_DONE: begin
                if (i_state.phase == usbep0_pkg::PH_DATA) begin
                    if (np_rem != 16'd0) begin
                        o_result.response      = usbep0_pkg::RSP_DATA;
                        o_result.packet_source = i_state.source_id;
                        o_result.packet_offset = i_state.sent_bytes;
                        o_result.packet_length = np_sz[6:0];
                    end else if (i_state.zlp_pending) begin
                        o_result.response      = usbep0_pkg::RSP_ZLP;
                        o_result.packet_source = i_state.source_id;
                        o_result.packet_offset = i_state.sent_bytes;
                    end else begin
                        o_result.response = usbep0_pkg::RSP_ARM;
                    end
                end
            end
            usbep0_pkg::ACT_OUT_DONE: begin
                o_result.transfer_done = (i_state.phase == usbep0_pkg::PH_STATUS);
            end
            usbep0_pkg::ACT_BUS_RESET: begin
                o_result.address_update = 1'b1;
                o_result.new_address    = 7'd0;
            end
            default: o_result.response = usbep0_pkg::RSP_NONE;
        endcase
    end

endmodule

// File: design/usb_ep0_control_transfer.sv
// ----------------------------------------------------------------------------
// usb_ep0_control_transfer - EP0 control transfer request handler
// Sequences standard, vendor and class control requests and their stages.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis carries one EP0 event per word: tuser is the event kind (setup,
//    IN done, OUT done, bus reset), tdata the setup packet fields.
//  - m_axis returns exactly one result word per event: tuser is the response
//    code, tdata the packet source, offset, length, address write and the
//    configuration and streaming flags after the event.
//  - i_cfg_we / i_cfg_index / i_cfg_data write the descriptor length
//    registers; change them only while no event is in flight.
//  - an accepted event waits in the input register, then passes the decode
//    into the result register.
//  - throughput is one event per cycle while m_axis_tready stays high; the
//    transfer state is updated by the single decode pass, so each event sees
//    the previous one's state.
//  - when the result is not taken, the result register holds it and the
//    input register still fills; s_axis_tready drops once both are full.
//  - reset clears all transfer state, the configuration and streaming flags
//    and returns the length registers to the default descriptor set.
// ----------------------------------------------------------------------------
module usb_ep0_control_transfer #(
    parameter int MAX_PACKET = usbep0_pkg::MAX_PACKET_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // event input
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // request_type, request_code, request_value, request_index, request_length
    input  logic [63:0]                        s_axis_tdata,
    // action
    input  logic [1:0]                         s_axis_tuser,
    // result output
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // packet_source, packet_offset, packet_length, address_update,
    // new_address, configured, streaming_on, transfer_done, zero fill
    output logic [39:0]                        m_axis_tdata,
    // response
    output logic [2:0]                         m_axis_tuser,
    // length register writes
    input  logic                               i_cfg_we,
    input  logic [usbep0_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [usbep0_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    usbep0_pkg::t_cfg    cfg;
    usbep0_pkg::t_item   in_item;
    usbep0_pkg::t_item   r_in;
    logic                r_in_valid;
    usbep0_pkg::t_state  r_state;
    usbep0_pkg::t_state  n_state;
    usbep0_pkg::t_result n_out;
    usbep0_pkg::t_result r_out;
    logic                r_out_valid;
    logic                advance;

    // descriptor length registers
    usbep0_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // unpack the input word
    assign in_item.action         = usbep0_pkg::t_action'(s_axis_tuser);
    assign in_item.request_type   = s_axis_tdata[7:0];
    assign in_item.request_code   = s_axis_tdata[15:8];
    assign in_item.request_value  = s_axis_tdata[31:16];
    assign in_item.request_index  = s_axis_tdata[47:32];
    assign in_item.request_length = s_axis_tdata[63:48];

    // pipeline flow: decode fires when the result register is free or drains
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in <= in_item;
        end
    end

    // request decode and transfer sequencing
    usbep0_decode #(
        .MAX_PACKET (MAX_PACKET)
    ) u_decode (
        .i_item       (r_in),
        .i_state      (r_state),
        .i_cfg        (cfg),
        .o_next_state (n_state),
        .o_result     (n_out)
    );

    // transfer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    // pack the result word
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.response;
    assign m_axis_tdata  = {2'b00,
                            r_out.transfer_done,
                            r_out.streaming_on,
                            r_out.configured,
                            r_out.new_address,
                            r_out.address_update,
                            r_out.packet_length,
                            r_out.packet_offset,
                            r_out.packet_source};

endmodule

// File: dv/tb_usb_ep0_control_transfer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_usb_ep0_control_transfer - testbench for the EP0 control transfer handler
// Drives setup, IN done, OUT done and bus reset events into the stream input
// and checks every result word against an in-bench model of the request
// decoder and data stage sequencer. Directed tests cover each request and
// the descriptor length registers; random control transfers follow under
// several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_usb_ep0_control_transfer;
    import usbep0_pkg::*;

    localparam int MAX_PKT = 64;

    // bmRequestType values used by the directed tests
    localparam logic [7:0] RTYPE_STD_IN    = 8'h80;
    localparam logic [7:0] RTYPE_STD_OUT   = 8'h00;
    localparam logic [7:0] RTYPE_CLASS_OUT = 8'h21;
    localparam logic [7:0] RTYPE_VENDOR_IN = 8'hC0;
    localparam logic [7:0] RTYPE_RESERVED  = 8'hE0;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // request_type, request_code, request_value, request_index, request_length
    logic [63:0]            s_axis_tdata;
    // action
    logic [1:0]             s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // packet_source, packet_offset, packet_length, address_update,
    // new_address, configured, streaming_on, transfer_done, zero fill
    logic [39:0]            m_axis_tdata;
    // response
    logic [2:0]             m_axis_tuser;
    logic                   i_cfg_we;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    // model state of the handler
    t_cfg        desc_len;
    t_phase      phase_q;
    logic [15:0] total_q;
    logic [15:0] sent_q;
    logic        zlp_q;
    logic [3:0]  src_q;
    logic        cfg_q;
    logic        stream_q;
    logic [6:0]  addr_q;
    t_result     ep0_answer;

    t_result     pending_responses[$];
    int          mismatch_count;
    int          events_sent;
    bit          idle_on;

    usb_ep0_control_transfer #(
        .MAX_PACKET(MAX_PKT)
    ) DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // watchdog
    initial begin
        #5_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // ------------------------------------------------------------------------
    // model of the request handler
    // ------------------------------------------------------------------------

    // next IN packet of the data stage, zlp after an exact multiple, then arm
    function automatic void emit_next_packet();
        logic [15:0] left;
        logic [15:0] sz;
        left = total_q - sent_q;
        if (left != 16'd0) begin
            sz = (left > MAX_PKT) ? 16'(MAX_PKT) : left;
            ep0_answer.response      = RSP_DATA;
            ep0_answer.packet_source = src_q;
            ep0_answer.packet_offset = sent_q;
            ep0_answer.packet_length = sz[6:0];
            sent_q = sent_q + sz;
            if (sz == MAX_PKT && sent_q == total_q)
                zlp_q = 1'b1;
        end else if (zlp_q) begin
            ep0_answer.response      = RSP_ZLP;
            ep0_answer.packet_source = src_q;
            ep0_answer.packet_offset = sent_q;
            zlp_q = 1'b0;
        end else begin
            phase_q = PH_STATUS;
            ep0_answer.response = RSP_ARM;
        end
    endfunction

    // start a data stage of min(wlen, object length) bytes
    function automatic void begin_transfer(input logic [3:0]  src,
                                           input logic [15:0] obj_len,
                                           input logic [15:0] wlen);
        logic [15:0] n;
        n = (wlen < obj_len) ? wlen : obj_len;
        src_q   = src;
        total_q = n;
        sent_q  = 16'd0;
        zlp_q   = 1'b0;
        phase_q = PH_DATA;
        if (n == 16'd0) begin
            ep0_answer.response      = RSP_ZLP;
            ep0_answer.packet_source = src;
            ep0_answer.packet_offset = 16'd0;
        end else begin
            emit_next_packet();
        end
    endfunction

    function automatic void stall_request();
        phase_q = PH_IDLE;
        ep0_answer.response = RSP_STALL;
    endfunction

    // expected result word of one event, updating the model state
    function automatic t_result compute_ep0_response(input t_item ev);
        logic [7:0]  lo;
        logic [15:0] obj_len;
        logic [3:0]  obj_src;
        logic        known;
        ep0_answer = '0;
        ep0_answer.response = RSP_NONE;
        lo = ev.request_value[7:0];
        case (ev.action)
            ACT_SETUP: begin
                total_q = ev.request_length;
                sent_q  = 16'd0;
                zlp_q   = 1'b0;
                case (ev.request_type[6:5])
                    RT_STANDARD: begin
                        case (ev.request_code)
                            REQ_GET_STATUS:
                                begin_transfer(SRC_STATUS, LEN_STATUS, ev.request_length);
                            REQ_SET_ADDRESS: begin
                                if (ev.request_index == 16'd0 && ev.request_length == 16'd0) begin
                                    addr_q = ev.request_value[6:0];
                                    ep0_answer.address_update = 1'b1;
                                    ep0_answer.new_address    = addr_q;
                                    begin_transfer(SRC_NONE, LEN_NONE, 16'd0);
                                end else begin
                                    stall_request();
                                end
                            end
                            REQ_GET_DESCRIPTOR: begin
                                known   = 1'b1;
                                obj_len = 16'd0;
                                obj_src = SRC_NONE;
                                case (ev.request_value[15:8])
                                    DESC_DEVICE: begin
                                        obj_src = SRC_DEVICE;
                                        obj_len = {8'd0, desc_len.device_len};
                                    end
                                    DESC_CONFIG: begin
                                        obj_src = SRC_CONFIG;
                                        obj_len = desc_len.config_len;
                                    end
                                    DESC_QUALIFIER: begin
                                        obj_src = SRC_QUALIFIER;
                                        obj_len = {8'd0, desc_len.qualifier_len};
                                    end
                                    DESC_STRING: begin
                                        case (lo)
                                            STR_LANGUAGE: begin
                                                obj_src = SRC_STRING0;
                                                obj_len = {8'd0, desc_len.string0_len};
                                            end
                                            STR_MANUFACTURER: begin
                                                obj_src = SRC_STRING1;
                                                obj_len = {8'd0, desc_len.string1_len};
                                            end
                                            STR_PRODUCT: begin
                                                obj_src = SRC_STRING2;
                                                obj_len = {8'd0, desc_len.string2_len};
                                            end
                                            default: known = 1'b0;
                                        endcase
                                    end
                                    default: known = 1'b0;
                                endcase
                                // unknown selector or empty descriptor
                                if (!known || obj_len == 16'd0)
                                    stall_request();
                                else
                                    begin_transfer(obj_src, obj_len, ev.request_length);
                            end
                            REQ_GET_CONFIG:
                                begin_transfer(SRC_CFG_BYTE, LEN_CFG_BYTE, ev.request_length);
                            REQ_SET_CONFIG: begin
                                if (lo <= 8'd1) begin
                                    cfg_q = lo[0];
                                    begin_transfer(SRC_NONE, LEN_NONE, 16'd0);
                                end else begin
                                    stall_request();
                                end
                            end
                            REQ_SET_INTERFACE: begin
                                // interface 0 has alt 0 only, interface 1 alt 0 and 1
                                if (ev.request_index[7:0] == 8'd0 && lo == 8'd0) begin
                                    begin_transfer(SRC_NONE, LEN_NONE, 16'd0);
                                end else if (ev.request_index[7:0] == 8'd1 && lo <= 8'd1) begin
                                    stream_q = lo[0];
                                    begin_transfer(SRC_NONE, LEN_NONE, 16'd0);
                                end else begin
                                    stall_request();
                                end
                            end
                            default: stall_request();
                        endcase
                    end
                    RT_CLASS: begin
                        phase_q = PH_FWD;
                        ep0_answer.response = RSP_FWD;
                    end
                    RT_VENDOR: begin
                        if (ev.request_code == REQ_KEEPALIVE)
                            begin_transfer(SRC_KEEPALIVE, LEN_KEEPALIVE, ev.request_length);
                        else
                            stall_request();
                    end
                    default: stall_request();
                endcase
            end
            ACT_IN_DONE: begin
                if (phase_q == PH_DATA)
                    emit_next_packet();
            end
            ACT_OUT_DONE: begin
                if (phase_q == PH_STATUS) begin
                    phase_q = PH_IDLE;
                    ep0_answer.transfer_done = 1'b1;
                end
            end
            default: begin
                // bus reset keeps configuration and streaming
                phase_q = PH_IDLE;
                addr_q  = 7'd0;
                ep0_answer.address_update = 1'b1;
                ep0_answer.new_address    = 7'd0;
            end
        endcase
        ep0_answer.configured   = cfg_q;
        ep0_answer.streaming_on = stream_q;
        return ep0_answer;
    endfunction

    // ------------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------------

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got_v);
        if (got_v !== want) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got_v);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin : check_results
        t_result want;
        t_result got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.response       = t_response'(m_axis_tuser);
            got.packet_source  = m_axis_tdata[3:0];
            got.packet_offset  = m_axis_tdata[19:4];
            got.packet_length  = m_axis_tdata[26:20];
            got.address_update = m_axis_tdata[27];
            got.new_address    = m_axis_tdata[34:28];
            got.configured     = m_axis_tdata[35];
            got.streaming_on   = m_axis_tdata[36];
            got.transfer_done  = m_axis_tdata[37];
            if (pending_responses.size() == 0) begin
                $display("%0t: unexpected result word, expected none actual %0h/%0h",
                         $time, m_axis_tuser, m_axis_tdata);
                mismatch_count++;
            end else begin
                want = pending_responses.pop_front();
                check_field("response", want.response, got.response);
                check_field("packet_source", want.packet_source, got.packet_source);
                check_field("packet_offset", want.packet_offset, got.packet_offset);
                check_field("packet_length", want.packet_length, got.packet_length);
                check_field("address_update", want.address_update, got.address_update);
                check_field("new_address", want.new_address, got.new_address);
                check_field("configured", want.configured, got.configured);
                check_field("streaming_on", want.streaming_on, got.streaming_on);
                check_field("transfer_done", want.transfer_done, got.transfer_done);
            end
        end
    end

    // result side back-pressure in random bursts
    initial begin : result_stall
        int unsigned hold;
        hold = 0;
        m_axis_tready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold != 0)
                hold--;
            else if (idle_on && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 18);
            m_axis_tready <= (hold == 0);
        end
    end

    // ------------------------------------------------------------------------
    // event generation and driving
    // ------------------------------------------------------------------------

    function automatic t_item make_event(input t_action act, input logic [7:0] rtype,
                                         input logic [7:0] code, input logic [15:0] value,
                                         input logic [15:0] index, input logic [15:0] wlen);
        t_item ev;
        ev.action         = act;
        ev.request_type   = rtype;
        ev.request_code   = code;
        ev.request_value  = value;
        ev.request_index  = index;
        ev.request_length = wlen;
        return ev;
    endfunction

    // non-setup event, setup fields random since they are ignored
    function automatic t_item bare_event(input t_action act);
        return make_event(act, $urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] pick_wlen();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return $urandom_range(0, 65535);
            3:       return 16'd64;
            default: return $urandom_range(1, 140);
        endcase
    endfunction

    function automatic logic [15:0] pick_length(input bit wide);
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return wide ? 16'hFFFF : 16'h00FF;
            2:       return 16'd64;
            3:       return 16'd128;
            4:       return 16'd1;
            default: return $urandom_range(1, wide ? 300 : 255);
        endcase
    endfunction

    // well-formed setup with random content, now and then a bad one
    function automatic t_item random_setup();
        logic [7:0]  rtype;
        logic [7:0]  code;
        logic [7:0]  dtype;
        logic [7:0]  sidx;
        logic [15:0] value;
        logic [15:0] index;
        logic [15:0] wlen;
        rtype      = RTYPE_STD_IN;
        rtype[7]   = $urandom_range(0, 1);
        rtype[4:0] = $urandom_range(0, 31);
        code       = $urandom_range(0, 255);
        value      = $urandom_range(0, 65535);
        index      = $urandom_range(0, 65535);
        wlen       = pick_wlen();
        case ($urandom_range(0, 15))
            0: code = REQ_GET_STATUS;
            1: begin
                code = REQ_SET_ADDRESS;
                if ($urandom_range(0, 3) != 0) begin
                    index = 16'd0;
                    wlen  = 16'd0;
                end
            end
            2, 3, 4, 5, 6: begin
                code = REQ_GET_DESCRIPTOR;
                case ($urandom_range(0, 4))
                    0:       dtype = DESC_DEVICE;
                    1:       dtype = DESC_CONFIG;
                    2:       dtype = DESC_QUALIFIER;
                    3:       dtype = DESC_STRING;
                    default: dtype = $urandom_range(0, 255);
                endcase
                case ($urandom_range(0, 3))
                    0:       sidx = STR_LANGUAGE;
                    1:       sidx = STR_MANUFACTURER;
                    2:       sidx = STR_PRODUCT;
                    default: sidx = $urandom_range(0, 255);
                endcase
                value = {dtype, sidx};
            end
            7: code = REQ_GET_CONFIG;
            8: begin
                code = REQ_SET_CONFIG;
                if ($urandom_range(0, 3) != 0)
                    value[7:0] = $urandom_range(0, 1);
            end
            9: begin
                code = REQ_SET_INTERFACE;
                if ($urandom_range(0, 3) != 0) begin
                    index[7:0] = $urandom_range(0, 1);
                    value[7:0] = $urandom_range(0, 1);
                end
            end
            10: begin
                rtype[6:5] = RT_VENDOR;
                if ($urandom_range(0, 3) != 0)
                    code = REQ_KEEPALIVE;
            end
            11: rtype[6:5] = RT_CLASS;
            12: rtype[6:5] = RT_RESERVED;
            default: ;
        endcase
        return make_event(ACT_SETUP, rtype, code, value, index, wlen);
    endfunction

    // present one word, wait for its handshake, record the expected result
    task automatic send_event(input t_item ev);
        int unsigned gap;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {ev.request_length, ev.request_index, ev.request_value,
                          ev.request_code, ev.request_type};
        s_axis_tuser  <= ev.action;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_responses.push_back(compute_ep0_response(ev));
        events_sent++;
    endtask

    // stop sending and let every outstanding result come back
    task automatic drain_events();
        s_axis_tvalid <= 1'b0;
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_length(input logic [2:0] idx, input logic [15:0] value);
        drain_events();
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_DEVICE_LEN:    desc_len.device_len    = value[7:0];
            CFG_CONFIG_LEN:    desc_len.config_len    = value;
            CFG_QUALIFIER_LEN: desc_len.qualifier_len = value[7:0];
            CFG_STRING0_LEN:   desc_len.string0_len   = value[7:0];
            CFG_STRING1_LEN:   desc_len.string1_len   = value[7:0];
            CFG_STRING2_LEN:   desc_len.string2_len   = value[7:0];
            default: ;
        endcase
    endtask

    // 0 all at maximum, 1 all empty, otherwise random
    task automatic set_all_lengths(input int mode);
        logic [15:0] pick [6];
        int i;
        for (i = 0; i < 6; i++) begin
            if (mode == 0)
                pick[i] = (i == CFG_CONFIG_LEN) ? 16'hFFFF : 16'h00FF;
            else if (mode == 1)
                pick[i] = 16'd0;
            else
                pick[i] = pick_length(i == CFG_CONFIG_LEN);
        end
        write_length(CFG_DEVICE_LEN, pick[CFG_DEVICE_LEN]);
        write_length(CFG_CONFIG_LEN, pick[CFG_CONFIG_LEN]);
        write_length(CFG_QUALIFIER_LEN, pick[CFG_QUALIFIER_LEN]);
        write_length(CFG_STRING0_LEN, pick[CFG_STRING0_LEN]);
        write_length(CFG_STRING1_LEN, pick[CFG_STRING1_LEN]);
        write_length(CFG_STRING2_LEN, pick[CFG_STRING2_LEN]);
    endtask

    // setup, every IN packet, then the status OUT
    task automatic run_transfer(input t_item ev);
        send_event(ev);
        while (phase_q == PH_DATA) send_event(bare_event(ACT_IN_DONE));
        if (phase_q == PH_STATUS)
            send_event(bare_event(ACT_OUT_DONE));
    endtask

    // control transfer with noise, replacement setups and early abandon
    task automatic random_transfer();
        int n_in;
        int k;
        if ($urandom_range(0, 9) == 0)
            send_event(bare_event(t_action'($urandom_range(0, 3))));
        else
            send_event(random_setup());
        n_in = 0;
        while (phase_q == PH_DATA && n_in < 12) begin
            k = $urandom_range(0, 39);
            if (k == 0)
                send_event(bare_event(t_action'($urandom_range(0, 3))));
            else if (k == 1)
                send_event(random_setup());
            else
                send_event(bare_event(ACT_IN_DONE));
            n_in++;
        end
        if (phase_q == PH_STATUS && $urandom_range(0, 9) != 0)
            send_event(bare_event(ACT_OUT_DONE));
        // forwarded class request ignores IN and OUT events
        if (phase_q == PH_FWD) begin
            for (k = $urandom_range(0, 2); k > 0; k--)
                send_event(bare_event($urandom_range(0, 1) ? ACT_IN_DONE : ACT_OUT_DONE));
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    task automatic test_standard_requests();
        run_transfer(make_event(ACT_SETUP, RTYPE_STD_IN, REQ_GET_STATUS,
                                16'h0000, 16'h0000, 16'hFFFF));
        run_transfer(make_event(ACT_SETUP, RTYPE_STD_IN, REQ_GET_DESCRIPTOR,
                                {DESC_DEVICE, 8'h00}, 16'h0000, 16'd8));
        // zero length request gives a single zlp
        send_event(make_event(ACT_SETUP, RTYPE_STD_IN, REQ_GET_CONFIG,
                              16'h0000, 16'h0000, 16'h0000));
    endtask

    task automatic test_address_and_bus_reset();
        run_transfer(make_event(ACT_SETUP, RTYPE_STD_OUT, REQ_SET_ADDRESS,
                                16'hFFFF, 16'h0000, 16'h0000));
        // set address with a data stage is refused
        send_event(make_event(ACT_SETUP, RTYPE_STD_OUT, REQ_SET_ADDRESS,
                              16'h0012, 16'h0000, 16'h0001));
        send_event(bare_event(ACT_BUS_RESET));
    endtask

    task automatic test_configuration_and_interface();
        send_event(make_event(ACT_SETUP, RTYPE_STD_OUT, REQ_SET_CONFIG,
                              16'hFF01, 16'h0000, 16'h0000));
        send_event(make_event(ACT_SETUP, RTYPE_STD_OUT, REQ_SET_CONFIG,
                              16'h0002, 16'h0000, 16'h0000));
        send_event(make_event(ACT_SETUP, RTYPE_STD_OUT, REQ_SET_INTERFACE,
                              16'h0001, 16'h0001, 16'h0000));
        send_event(make_event(ACT_SETUP, RTYPE_STD_OUT, REQ_SET_INTERFACE,
                              16'h0001, 16'h0000, 16'h0000));
        send_event(make_event(ACT_SETUP, RTYPE_STD_IN, REQ_GET_DESCRIPTOR,
                              {DESC_STRING, 8'd3}, 16'h0409, 16'd255));
        send_event(make_event(ACT_SETUP, RTYPE_STD_IN, 8'hFF,
                              16'h0000, 16'h0000, 16'd64));
    endtask

    task automatic test_vendor_and_class();
        send_event(make_event(ACT_SETUP, RTYPE_VENDOR_IN, REQ_KEEPALIVE,
                              16'h0000, 16'h0000, 16'hFFFF));
        send_event(bare_event(ACT_IN_DONE));
        send_event(make_event(ACT_SETUP, RTYPE_CLASS_OUT, 8'h81,
                              16'h0100, 16'h0001, 16'd2));
        send_event(bare_event(ACT_IN_DONE));
        send_event(bare_event(ACT_OUT_DONE));
        send_event(make_event(ACT_SETUP, RTYPE_VENDOR_IN, 8'h02,
                              16'h0000, 16'h0000, 16'd4));
        send_event(make_event(ACT_SETUP, RTYPE_RESERVED, REQ_GET_DESCRIPTOR,
                              {DESC_DEVICE, 8'h00}, 16'h0000, 16'd18));
        // stray IN while idle
        send_event(bare_event(ACT_IN_DONE));
    endtask

    task automatic test_descriptor_lengths();
        write_length(CFG_STRING1_LEN, 16'd64);
        write_length(CFG_STRING2_LEN, 16'd255);
        write_length(CFG_DEVICE_LEN, 16'd0);
        write_length(CFG_QUALIFIER_LEN, 16'd255);
        write_length(CFG_CONFIG_LEN, 16'hFFFF);
        write_length(CFG_STRING0_LEN, 16'd0);
        // exact multiple of the packet size ends with a zlp
        run_transfer(make_event(ACT_SETUP, RTYPE_STD_IN, REQ_GET_DESCRIPTOR,
                                {DESC_STRING, STR_MANUFACTURER}, 16'h0409, 16'hFFFF));
        run_transfer(make_event(ACT_SETUP, RTYPE_STD_IN, REQ_GET_DESCRIPTOR,
                                {DESC_STRING, STR_PRODUCT}, 16'h0409, 16'd200));
        send_event(make_event(ACT_SETUP, RTYPE_STD_IN, REQ_GET_DESCRIPTOR,
                              {DESC_DEVICE, 8'h00}, 16'h0000, 16'd18));
        run_transfer(make_event(ACT_SETUP, RTYPE_STD_IN, REQ_GET_DESCRIPTOR,
                                {DESC_QUALIFIER, 8'h00}, 16'h0000, 16'd128));
        // long configuration read abandoned by a bus reset
        send_event(make_event(ACT_SETUP, RTYPE_STD_IN, REQ_GET_DESCRIPTOR,
                              {DESC_CONFIG, 8'h00}, 16'h0000, 16'hFFFF));
        repeat (5) send_event(bare_event(ACT_IN_DONE));
        send_event(bare_event(ACT_BUS_RESET));
        send_event(make_event(ACT_SETUP, RTYPE_STD_IN, REQ_GET_DESCRIPTOR,
                              {DESC_STRING, STR_LANGUAGE}, 16'h0000, 16'd255));
    endtask

    task automatic test_random_transfers();
        int round;
        int target;
        for (round = 0; round < 6; round++) begin
            set_all_lengths(round);
            target = events_sent + 140;
            while (events_sent < target) random_transfer();
        end
    endtask

    task automatic test_back_to_back();
        int target;
        idle_on = 1'b0;
        set_all_lengths(2);
        target = events_sent + 140;
        while (events_sent < target) random_transfer();
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        mismatch_count = 0;
        events_sent    = 0;
        idle_on        = 1'b1;
        // model state after reset
        desc_len.device_len    = RST_DEVICE_LEN;
        desc_len.config_len    = RST_CONFIG_LEN;
        desc_len.qualifier_len = RST_QUALIFIER_LEN;
        desc_len.string0_len   = RST_STRING0_LEN;
        desc_len.string1_len   = RST_STRING1_LEN;
        desc_len.string2_len   = RST_STRING2_LEN;
        phase_q  = PH_IDLE;
        total_q  = 16'd0;
        sent_q   = 16'd0;
        zlp_q    = 1'b0;
        src_q    = SRC_NONE;
        cfg_q    = 1'b0;
        stream_q = 1'b0;
        addr_q   = 7'd0;

        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= ACT_SETUP;
        i_cfg_we      <= 1'b0;
        i_cfg_index   <= CFG_DEVICE_LEN;
        i_cfg_data    <= '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_standard_requests();
        test_address_and_bus_reset();
        test_configuration_and_interface();
        test_vendor_and_class();
        test_descriptor_lengths();
        test_random_transfers();
        test_back_to_back();
        drain_events();

        if (mismatch_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
